// ===== design/bad_pkg.sv =====
// Package for the block average downsampler: configuration register codes,
// register widths and reset values, result flag type and default parameter values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bad_pkg;

  // Default values for the top level parameters.
  localparam int DEF_MAX_OUT_WIDTH = 1024;
  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_MAX_LEVEL     = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_LEVEL   = 2'd0,
    REG_OUT_WIDTH   = 2'd1,
    REG_OUT_HEIGHT  = 2'd2,
    REG_FRAME_COUNT = 2'd3
  } cfg_reg_t;

  // Register widths.
  localparam int LEVEL_W  = 3;
  localparam int OWIDTH_W = 11;
  localparam int OHEIGHT_W = 11;
  localparam int FRAMES_W = 16;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]   LEVEL_RST   = 3'd1;
  localparam logic [OWIDTH_W-1:0]  OWIDTH_RST  = 11'd1024;
  localparam logic [OHEIGHT_W-1:0] OHEIGHT_RST = 11'd1024;
  localparam logic [FRAMES_W-1:0]  FRAMES_RST  = 16'd1;

  // Output rows per frame are limited to this count.
  localparam int OUT_ROW_LIMIT = 1024;
  localparam int ROW_W         = 10;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic stack_end;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== design/block_average_downsampler.sv =====
// Block average downsampler: averages 2^level x 2^level pixel blocks of a raster
// frame stack into one output pixel. Uses bad_pkg for register codes and types.
// Results pass stage 1, then the output register or skid stage. Throughput: one
// sample per cycle while in_stall is low, set by the line store's one read and one
// write port; a write-to-read bypass keeps back-to-back updates of one column exact.
// Reset: synchronous, active low; registers take their documented defaults and all
// counters clear. The line store is not cleared: the first input row of every block
// overwrites its entry, so no clearing pass is needed and samples are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module block_average_downsampler #(
  parameter int MAX_OUT_WIDTH = bad_pkg::DEF_MAX_OUT_WIDTH,
  parameter int SAMPLE_BITS   = bad_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_LEVEL     = bad_pkg::DEF_MAX_LEVEL
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration write port.
  input  wire logic                          cfg_wr_en,
  input  wire logic [bad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bad_pkg::CFG_DATA_W-1:0] cfg_data,
  // Sample channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [SAMPLE_BITS-1:0]        in_sample,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SAMPLE_BITS-1:0]             out_average,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  output logic                               out_stack_end
);

  // Sums of a whole block never overflow at this width.
  localparam int SUM_W  = SAMPLE_BITS + 2 * MAX_LEVEL;
  localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
  // Width in which the column counter and the width register are compared.
  localparam int WCMP_W = (COL_W + 1 > bad_pkg::OWIDTH_W) ? COL_W + 1 : bad_pkg::OWIDTH_W;
  localparam int HCMP_W = bad_pkg::OHEIGHT_W;
  localparam int LVL_W  = bad_pkg::LEVEL_W;
  localparam int FRM_W  = bad_pkg::FRAMES_W;
  localparam int ROW_W  = bad_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [LVL_W-1:0]                bin_level_r;
  logic [bad_pkg::OWIDTH_W-1:0]    out_width_r;
  logic [bad_pkg::OHEIGHT_W-1:0]   out_height_r;
  logic [FRM_W-1:0]                frame_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_level_r   <= bad_pkg::LEVEL_RST;
      out_width_r   <= bad_pkg::OWIDTH_RST;
      out_height_r  <= bad_pkg::OHEIGHT_RST;
      frame_count_r <= bad_pkg::FRAMES_RST;
    end else if (cfg_wr_en) begin
      case (bad_pkg::cfg_reg_t'(cfg_index))
        bad_pkg::REG_BIN_LEVEL:   bin_level_r   <= cfg_data[LVL_W-1:0];
        bad_pkg::REG_OUT_WIDTH:   out_width_r   <= cfg_data[bad_pkg::OWIDTH_W-1:0];
        bad_pkg::REG_OUT_HEIGHT:  out_height_r  <= cfg_data[bad_pkg::OHEIGHT_W-1:0];
        bad_pkg::REG_FRAME_COUNT: frame_count_r <= cfg_data[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective sizes. Out-of-range register values are clamped so that the
  // counters always wrap at a sensible position.
  // ---------------------------------------------------------------------------
  logic [LVL_W-1:0]      level;
  logic [MAX_LEVEL-1:0]  bin_m1;
  logic [WCMP_W-1:0]     width_raw;
  logic [WCMP_W-1:0]     width_eff;
  logic [HCMP_W-1:0]     height_eff;
  logic [FRM_W-1:0]      frames_eff;

  always_comb begin
    level     = (bin_level_r > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : bin_level_r;
    bin_m1    = {MAX_LEVEL{1'b1}} >> (LVL_W'(MAX_LEVEL) - level);
    width_raw = WCMP_W'(out_width_r);
    if (width_raw == '0) begin
      width_eff = WCMP_W'(1);
    end else if (width_raw > WCMP_W'(MAX_OUT_WIDTH)) begin
      width_eff = WCMP_W'(MAX_OUT_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (out_height_r == '0) begin
      height_eff = HCMP_W'(1);
    end else if (out_height_r > HCMP_W'(bad_pkg::OUT_ROW_LIMIT)) begin
      height_eff = HCMP_W'(bad_pkg::OUT_ROW_LIMIT);
    end else begin
      height_eff = out_height_r;
    end
    frames_eff = (frame_count_r == '0) ? FRM_W'(1) : frame_count_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position counters and horizontal run sum, updated on each
  // sample transfer. The line store read for the current column is issued here.
  // ---------------------------------------------------------------------------
  logic                  in_xfer;
  logic [MAX_LEVEL-1:0]  bin_col_r;
  logic [COL_W-1:0]      out_col_r;
  logic [MAX_LEVEL-1:0]  bin_row_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [FRM_W-1:0]      frame_idx_r;
  logic [SUM_W-1:0]      run_sum_r;

  logic                  pix_last;
  logic                  col_last;
  logic                  brow_last;
  logic                  row_last;
  logic                  frame_last;
  logic [SUM_W-1:0]      run_total;

  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    pix_last   = bin_col_r >= bin_m1;
    col_last   = WCMP_W'(out_col_r) >= (width_eff - WCMP_W'(1));
    brow_last  = bin_row_r >= bin_m1;
    row_last   = HCMP_W'(out_row_r) >= (height_eff - HCMP_W'(1));
    frame_last = frame_idx_r >= (frames_eff - FRM_W'(1));
    run_total  = run_sum_r + SUM_W'(in_sample);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_col_r   <= '0;
      out_col_r   <= '0;
      bin_row_r   <= '0;
      out_row_r   <= '0;
      frame_idx_r <= '0;
      run_sum_r   <= '0;
    end else if (in_xfer) begin
      run_sum_r <= pix_last ? '0 : run_total;
      if (!pix_last) begin
        bin_col_r <= bin_col_r + MAX_LEVEL'(1);
      end else begin
        bin_col_r <= '0;
        if (!col_last) begin
          out_col_r <= out_col_r + COL_W'(1);
        end else begin
          out_col_r <= '0;
          if (!brow_last) begin
            bin_row_r <= bin_row_r + MAX_LEVEL'(1);
          end else begin
            bin_row_r <= '0;
            if (!row_last) begin
              out_row_r <= out_row_r + ROW_W'(1);
            end else begin
              out_row_r   <= '0;
              frame_idx_r <= frame_last ? '0 : frame_idx_r + FRM_W'(1);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one partial block sum per output column. Read data is
  // registered; the write comes from stage 1 in the following cycle.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] line_mem [MAX_OUT_WIDTH];
  logic [SUM_W-1:0] mem_q_r;
  logic             mem_we;
  logic [SUM_W-1:0] total;

  // Stage 1 registers.
  logic                s1_vld_r;
  logic                s1_pix_last_r;
  logic                s1_first_r;
  logic                s1_emit_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [SUM_W-1:0]    s1_run_r;
  logic [LVL_W-1:0]    s1_level_r;
  bad_pkg::res_flags_t s1_flags_r;

  always_ff @(posedge clk) begin
    mem_q_r <= line_mem[out_col_r];
    if (mem_we) begin
      line_mem[s1_col_r] <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_last_r        <= pix_last;
      s1_first_r           <= (bin_row_r == '0);
      s1_emit_r            <= pix_last && brow_last;
      s1_col_r             <= out_col_r;
      s1_run_r             <= run_total;
      s1_level_r           <= level;
      s1_flags_r.row_end   <= col_last;
      s1_flags_r.frame_end <= col_last && row_last;
      s1_flags_r.stack_end <= col_last && row_last && frame_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: fold the run into the column's entry and write it back. A write
  // made at the edge that also issued this item's read is not yet in the read
  // data, so it is bypassed from the last-write registers.
  // ---------------------------------------------------------------------------
  logic             wr_vld_r;
  logic [COL_W-1:0] wr_col_r;
  logic [SUM_W-1:0] wr_data_r;
  logic [SUM_W-1:0] base;
  logic [SAMPLE_BITS-1:0] s1_average;
  logic             s1_res;

  always_comb begin
    base       = (wr_vld_r && (wr_col_r == s1_col_r)) ? wr_data_r : mem_q_r;
    total      = s1_first_r ? s1_run_r : (base + s1_run_r);
    mem_we     = s1_vld_r && s1_pix_last_r;
    s1_average = SAMPLE_BITS'(total >> {s1_level_r, 1'b0});
    s1_res     = s1_vld_r && s1_emit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wr_col_r  <= s1_col_r;
      wr_data_r <= total;
    end
  end

  // ---------------------------------------------------------------------------
  // Result output register with a skid stage. Stage 1 always advances; when a
  // result meets a stalled output register it parks in the skid stage, and
  // sample transfers pause until the skid stage has drained.
  // ---------------------------------------------------------------------------
  logic                   out_vld_r;
  logic [SAMPLE_BITS-1:0] out_avg_r;
  bad_pkg::res_flags_t    out_flags_r;
  logic                   skid_vld_r;
  logic [SAMPLE_BITS-1:0] skid_avg_r;
  bad_pkg::res_flags_t    skid_flags_r;
  logic                   out_free;

  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = skid_vld_r || (s1_res && out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= s1_res;
      end
    end else if (s1_res) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_avg_r   <= skid_avg_r;
        out_flags_r <= skid_flags_r;
      end else if (s1_res) begin
        out_avg_r   <= s1_average;
        out_flags_r <= s1_flags_r;
      end
    end else if (s1_res) begin
      skid_avg_r   <= s1_average;
      skid_flags_r <= s1_flags_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_average   = out_avg_r;
  assign out_row_end   = out_flags_r.row_end;
  assign out_frame_end = out_flags_r.frame_end;
  assign out_stack_end = out_flags_r.stack_end;

endmodule

`default_nettype wire
